// File: rtl/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam int LINE_LIMIT_DEFAULT = 70;

    localparam int PIXEL_W = 32;
    localparam int MAXVAL_W = 16;
    localparam int BYTE_W = 8;
    localparam int COL_W = 8;
    localparam int NUM_DIGITS = 5;
    localparam int DIG_CNT_W = 3;
    localparam int DIGIT_W = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic REG_MAX_VALUE = 1'b0;
    localparam logic REG_BINARY_MODE = 1'b1;

    localparam logic [MAXVAL_W-1:0] MAX_VALUE_RESET = 16'd255;
    localparam logic BINARY_MODE_RESET = 1'b1;
    localparam logic [MAXVAL_W-1:0] NARROW_MAX = 16'h00FF;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [16:0] RECIP_TEN = 17'd52429;
    localparam int RECIP_SHIFT = 19;

    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NL = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    // byte source select
    localparam logic [2:0] SEL_ERR = 3'd0;
    localparam logic [2:0] SEL_HI = 3'd1;
    localparam logic [2:0] SEL_LO = 3'd2;
    localparam logic [2:0] SEL_SEP = 3'd3;
    localparam logic [2:0] SEL_NL = 3'd4;
    localparam logic [2:0] SEL_DIGIT = 3'd5;

    typedef struct packed {
        logic [MAXVAL_W-1:0] max_value;
        logic                binary_mode;
    } cfg_t;

    typedef struct packed {
        logic       capture;
        logic       div_init;
        logic       div_step;
        logic       sep_apply;
        logic       digit_dec;
        logic       col_clear;
        logic       set_err;
        logic       emit;
        logic [2:0] emit_sel;
        logic       emit_end;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic err_latched;
        logic out_of_range;
        logic binary;
        logic wide;
        logic div_last;
        logic sep_nl;
        logic col_nonzero;
        logic dig_one;
        logic last;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// File: rtl/pps_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel;
    logic        first_of_image;
    logic        last_of_image;

    modport source (output valid, output pixel, output first_of_image,
                    output last_of_image, input ready);
    modport sink (input valid, input pixel, input first_of_image,
                  input last_of_image, output ready);
endinterface

`default_nettype wire

// File: rtl/pps_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_error;
    logic       end_of_run;

    modport source (output valid, output out_byte, output is_error,
                    output end_of_run, input ready);
    modport sink (input valid, input out_byte, input is_error,
                  input end_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/pps_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_apb_regs
    import pps_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [MAXVAL_W-1:0] max_value_reg;
    logic                binary_mode_reg;
    logic                wr_en;
    logic                reg_idx;

    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= MAX_VALUE_RESET;
            binary_mode_reg <= BINARY_MODE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAX_VALUE:   max_value_reg <= pwdata[MAXVAL_W-1:0];
                REG_BINARY_MODE: binary_mode_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MAX_VALUE:   prdata = {{(APB_DATA_W-MAXVAL_W){1'b0}}, max_value_reg};
            REG_BINARY_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, binary_mode_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.max_value = max_value_reg;
    assign cfg.binary_mode = binary_mode_reg;

endmodule

`default_nettype wire

// File: rtl/pps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl
    import pps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  ctrl_sts_t      sts,
    output ctrl_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_BHI   = 4'd3;
    localparam logic [3:0] S_BLO   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SEP   = 4'd6;
    localparam logic [3:0] S_DIGIT = 4'd7;
    localparam logic [3:0] S_NL    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.emit_sel = SEL_ERR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.div_init = 1'b1;
                if (sts.err_latched)
                    state_next = S_IDLE;
                else if (sts.out_of_range)
                    state_next = S_ERR;
                else if (sts.binary)
                    state_next = sts.wide ? S_BHI : S_BLO;
                else
                    state_next = S_DIV;
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = SEL_ERR;
                    cmd.emit_end = 1'b1;
                    cmd.set_err = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BHI:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = SEL_HI;
                    state_next = S_BLO;
                end
            end
            S_BLO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = SEL_LO;
                    cmd.emit_end = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_SEP;
            end
            S_SEP:
            begin
                if (sts.sep_nl || sts.col_nonzero)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.emit_sel = sts.sep_nl ? SEL_NL : SEL_SEP;
                        cmd.sep_apply = 1'b1;
                        state_next = S_DIGIT;
                    end
                end
                else
                begin
                    cmd.sep_apply = 1'b1;
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = SEL_DIGIT;
                    cmd.emit_end = sts.dig_one & ~sts.last;
                    cmd.digit_dec = 1'b1;
                    if (sts.dig_one)
                        state_next = sts.last ? S_NL : S_IDLE;
                end
            end
            S_NL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_sel = SEL_NL;
                    cmd.emit_end = 1'b1;
                    cmd.col_clear = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_datapath
    import pps_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  cfg_t                    cfg,
    input  ctrl_cmd_t               cmd,
    output ctrl_sts_t               sts,
    input  wire logic [PIXEL_W-1:0] pixel,
    input  wire logic               first_of_image,
    input  wire logic               last_of_image,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [BYTE_W-1:0]       out_byte,
    output logic                    is_error,
    output logic                    end_of_run
);

    logic [PIXEL_W-1:0]   pix_reg;
    logic                 last_reg;
    logic [COL_W-1:0]     column_reg;
    logic                 err_reg;
    logic [MAXVAL_W-1:0]  num_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;
    logic [DIGIT_W-1:0]   digits_reg [NUM_DIGITS];
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic                 is_error_reg;
    logic                 end_of_run_reg;

    logic [32:0]          prod;
    logic [MAXVAL_W-1:0]  quot;
    logic [MAXVAL_W-1:0]  rem;
    logic [COL_W:0]       col_sum;
    logic [COL_W-1:0]     col_base;
    logic [DIG_CNT_W-1:0] dig_idx;
    logic [BYTE_W-1:0]    byte_sel;

    // divide by ten through the reciprocal
    assign prod = {16'b0, num_reg} * {16'b0, RECIP_TEN};
    assign quot = prod[RECIP_SHIFT +: MAXVAL_W];
    assign rem = num_reg - ((quot << 3) + (quot << 1));

    assign col_sum = {1'b0, column_reg} + {{(COL_W+1-DIG_CNT_W){1'b0}}, dig_cnt_reg};
    assign dig_idx = dig_cnt_reg - 3'd1;

    assign sts.out_free = ~out_valid_reg | out_ready;
    assign sts.err_latched = err_reg;
    assign sts.out_of_range = pix_reg > {{(PIXEL_W-MAXVAL_W){1'b0}}, cfg.max_value};
    assign sts.binary = cfg.binary_mode;
    assign sts.wide = cfg.max_value > NARROW_MAX;
    assign sts.div_last = (quot == '0) || (dig_cnt_reg == DIG_CNT_W'(NUM_DIGITS - 1));
    assign sts.sep_nl = col_sum >= (COL_W+1)'(LINE_LIMIT);
    assign sts.col_nonzero = column_reg != '0;
    assign sts.dig_one = dig_cnt_reg == 3'd1;
    assign sts.last = last_reg;

    always_comb
    begin
        if (sts.sep_nl)
            col_base = '0;
        else if (sts.col_nonzero)
            col_base = column_reg + 8'd1;
        else
            col_base = column_reg;
    end

    always_comb
    begin
        case (cmd.emit_sel)
            SEL_HI:    byte_sel = pix_reg[15:8];
            SEL_LO:    byte_sel = pix_reg[7:0];
            SEL_SEP:   byte_sel = CHAR_SPACE;
            SEL_NL:    byte_sel = CHAR_NL;
            SEL_DIGIT: byte_sel = CHAR_ZERO + {4'b0, digits_reg[dig_idx]};
            default:   byte_sel = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= pixel;
            last_reg <= last_of_image;
        end
        if (cmd.div_init)
            num_reg <= pix_reg[MAXVAL_W-1:0];
        else if (cmd.div_step)
        begin
            num_reg <= quot;
            digits_reg[dig_cnt_reg] <= rem[DIGIT_W-1:0];
        end
        if (cmd.emit)
        begin
            out_byte_reg <= byte_sel;
            is_error_reg <= (cmd.emit_sel == SEL_ERR);
            end_of_run_reg <= cmd.emit_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            err_reg <= 1'b0;
            dig_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture && first_of_image)
            begin
                column_reg <= '0;
                err_reg <= 1'b0;
            end
            else if (cmd.sep_apply)
                column_reg <= col_base + {{(COL_W-DIG_CNT_W){1'b0}}, dig_cnt_reg};
            else if (cmd.col_clear)
                column_reg <= '0;
            if (cmd.set_err)
                err_reg <= 1'b1;
            if (cmd.div_init)
                dig_cnt_reg <= '0;
            else if (cmd.div_step)
                dig_cnt_reg <= dig_cnt_reg + 3'd1;
            else if (cmd.digit_dec)
                dig_cnt_reg <= dig_idx;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign is_error = is_error_reg;
    assign end_of_run = end_of_run_reg;

endmodule

`default_nettype wire

// File: rtl/pgm_pixel_serializer_core.sv
// channel   | dir | payload                                   | transfer when
// ----------+-----+-------------------------------------------+-----------------
// in_ch     | in  | pixel[31:0], first_of_image, last_of_image | valid && ready
// out_ch    | out | out_byte[7:0], is_error, end_of_run        | valid && ready
// apb       | in  | max_value (0x0), binary_mode (0x4)         | psel&penable&pwrite
//
// one pixel at a time: capture and check, then nothing after an error, one error byte,
// or one or two bytes in binary; text mode divides by ten once per digit, passes the
// separator slot even when none is sent, then sends each digit and a last newline
// output register lets the next pixel be taken while the last byte waits
// a stalled output holds the sequencer; async active-low reset, no clear pass
`timescale 1ns / 1ps
`default_nettype none

module pgm_pixel_serializer_core
    import pps_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    pps_in_if.sink                     in_ch,
    pps_out_if.source                  out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      in_ready;

    assign in_ch.ready = in_ready;

    pps_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pps_datapath #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .pixel          (in_ch.pixel),
        .first_of_image (in_ch.first_of_image),
        .last_of_image  (in_ch.last_of_image),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_byte       (out_ch.out_byte),
        .is_error       (out_ch.is_error),
        .end_of_run     (out_ch.end_of_run)
    );

endmodule

`default_nettype wire

// File: rtl/pps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pps_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       is_error,
    input wire logic       end_of_run
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(is_error) && $stable(end_of_run))
    else $error("stalled result changed");

    // an error result is a zero byte that closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_error |-> out_byte == 8'h00 && end_of_run)
    else $error("malformed error result");

    // one pixel in flight: no transfer straight after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

    // handshake outputs are always known out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}))
    else $error("unknown handshake output");

endmodule

bind pgm_pixel_serializer_core pps_checker u_pps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .is_error   (out_ch.is_error),
    .end_of_run (out_ch.end_of_run)
);

`default_nettype wire

// File: verif/tb_pgm_pixel_serializer_core.sv
`timescale 1ns / 1ps

module tb_pgm_pixel_serializer_core;
    import pps_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_PIXELS = 47;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_VALUE = {REG_MAX_VALUE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_BINARY_MODE = {REG_BINARY_MODE, 2'b00};

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               first;
        logic               last;
        logic               hold;
    } pix_item_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              err;
        logic              eor;
    } pgm_byte_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    pps_in_if in_if ();
    pps_out_if out_if ();

    pgm_pixel_serializer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pix_item_t pending_pixels[$];
    pgm_byte_t expected_bytes[$];
    int bytes_expected = 0;
    int bytes_seen = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    // serializer state as predicted
    logic [MAXVAL_W-1:0] cfg_max = MAX_VALUE_RESET;
    logic                cfg_binary = BINARY_MODE_RESET;
    logic [COL_W-1:0]    text_col = '0;
    logic                err_seen = 1'b0;

    // random image generator state
    int  gen_left = 0;
    logic gen_bad = 1'b0;
    logic gen_noisy = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_bytes(input pix_item_t it);
        pgm_byte_t run[$];
        logic [BYTE_W-1:0] digs[NUM_DIGITS];
        int ndig;
        int unsigned num;
        int unsigned pos;
        if (it.first)
        begin
            text_col = '0;
            err_seen = 1'b0;
        end
        if (err_seen)
            return;
        if (it.pixel > {16'h0000, cfg_max})
        begin
            err_seen = 1'b1;
            run.push_back('{8'h00, 1'b1, 1'b0});
        end
        else if (cfg_binary)
        begin
            if (cfg_max > NARROW_MAX)
                run.push_back('{it.pixel[15:8], 1'b0, 1'b0});
            run.push_back('{it.pixel[7:0], 1'b0, 1'b0});
        end
        else
        begin
            num = it.pixel[15:0];
            ndig = 0;
            do
            begin
                digs[ndig] = CHAR_ZERO + BYTE_W'(num % 10);
                num = num / 10;
                ndig++;
            end
            while (num != 0);
            pos = text_col;
            if (pos + ndig >= LINE_LIMIT_DEFAULT)
            begin
                run.push_back('{CHAR_NL, 1'b0, 1'b0});
                pos = 0;
            end
            else if (pos != 0)
            begin
                run.push_back('{CHAR_SPACE, 1'b0, 1'b0});
                pos++;
            end
            pos += ndig;
            for (int i = ndig - 1; i >= 0; i--)
                run.push_back('{digs[i], 1'b0, 1'b0});
            if (it.last && pos != 0)
            begin
                run.push_back('{CHAR_NL, 1'b0, 1'b0});
                pos = 0;
            end
            text_col = COL_W'(pos);
        end
        run[run.size() - 1].eor = 1'b1;
        foreach (run[i])
            expected_bytes.push_back(run[i]);
        bytes_expected += run.size();
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
            in_if.pixel <= '0;
            in_if.first_of_image <= 1'b0;
            in_if.last_of_image <= 1'b0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
                predict_bytes(pending_pixels.pop_front());
            if (!(in_if.valid && !in_if.ready))
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct
                    && (!pending_pixels[0].hold || bytes_seen == bytes_expected))
                begin
                    in_if.valid <= 1'b1;
                    in_if.pixel <= pending_pixels[0].pixel;
                    in_if.first_of_image <= pending_pixels[0].first;
                    in_if.last_of_image <= pending_pixels[0].last;
                end
                else
                    in_if.valid <= 1'b0;
            end
        end
    end

    // byte monitor
    always @(posedge clk or negedge rst_n)
    begin
        pgm_byte_t want;
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                bytes_seen <= bytes_seen + 1;
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected transfer byte=%h err=%b end=%b", $time,
                             out_if.out_byte, out_if.is_error, out_if.end_of_run);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_if.out_byte !== want.data || out_if.is_error !== want.err
                        || out_if.end_of_run !== want.eor)
                    begin
                        $display("%0t: mismatch expected byte=%h err=%b end=%b got byte=%h err=%b end=%b",
                                 $time, want.data, want.err, want.eor,
                                 out_if.out_byte, out_if.is_error, out_if.end_of_run);
                        fail_count++;
                    end
                end
            end
            out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_pixel(input logic [PIXEL_W-1:0] pixel, input logic first,
                               input logic last, input logic hold);
        pending_pixels.push_back('{pixel, first, last, hold});
    endtask

    task automatic drain_outputs();
        while (pending_pixels.size() != 0 || in_if.valid || bytes_seen != bytes_expected)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // upper data bits carry junk, the block keeps only the register width
    task automatic set_config(input logic [MAXVAL_W-1:0] max_value, input logic binary);
        drain_outputs();
        write_reg(ADDR_MAX_VALUE, {16'($urandom), max_value});
        cfg_max = max_value;
        write_reg(ADDR_BINARY_MODE, {31'($urandom), binary});
        cfg_binary = binary;
        @(negedge clk);
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int unsigned lim;
        int r;
        r = $urandom_range(99);
        if (gen_noisy && r < 10)
        begin
            if (r < 5)
                return $urandom();
            return PIXEL_W'(cfg_max) + 32'd1 + $urandom_range(0, 3);
        end
        r = $urandom_range(99);
        if (r < 10)
            return PIXEL_W'(cfg_max);
        if (r < 18)
            return '0;
        if (r < 45)
        begin
            lim = 1;
            repeat ($urandom_range(1, NUM_DIGITS)) lim = lim * 10;
            lim = lim - 1;
            if (lim > cfg_max)
                lim = cfg_max;
            return $urandom_range(0, lim);
        end
        return $urandom_range(0, cfg_max);
    endfunction

    task automatic queue_random(input int n_live);
        pix_item_t it;
        int live;
        int r;
        live = 0;
        while (live < n_live)
        begin
            it.hold = ($urandom_range(99) == 0);
            if (gen_left == 0)
            begin
                gen_left = ($urandom_range(9) == 0) ? $urandom_range(40, 90)
                                                    : $urandom_range(1, 30);
                gen_noisy = ($urandom_range(99) < 30);
                it.first = 1'b1;
            end
            else
                it.first = 1'b0;
            gen_left--;
            it.last = (gen_left == 0);
            // broken framing now and then
            r = $urandom_range(99);
            if (r < 3)
                it.first = ~it.first;
            else if (r < 6)
                it.last = ~it.last;
            if (it.first)
                gen_bad = 1'b0;
            it.pixel = pick_pixel();
            if (!gen_bad)
                live++;
            if (it.pixel > {16'h0000, cfg_max})
                gen_bad = 1'b1;
            pending_pixels.push_back(it);
        end
    endtask

    task automatic run_phase(input logic [MAXVAL_W-1:0] max_value, input logic binary,
                             input int src_pct, input int snk_pct);
        set_config(max_value, binary);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        queue_random(PHASE_PIXELS);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: narrow binary
        queue_pixel(32'd0, 1'b1, 1'b0, 1'b0);
        queue_pixel(32'd255, 1'b0, 1'b0, 1'b0);
        queue_pixel(32'hA5, 1'b0, 1'b0, 1'b0);
        queue_pixel(32'd1, 1'b0, 1'b1, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        queue_pixel(32'd5, 1'b0, 1'b1, 1'b0);
        queue_pixel(32'd256, 1'b1, 1'b1, 1'b0);
        queue_pixel(32'd7, 1'b1, 1'b1, 1'b0);

        // wide binary
        set_config(16'hFFFF, 1'b1);
        queue_pixel(32'hABCD, 1'b1, 1'b0, 1'b0);
        queue_pixel(32'd65535, 1'b0, 1'b0, 1'b0);
        queue_pixel(32'd65536, 1'b0, 1'b1, 1'b0);

        // text, full range, sender waits for every byte before the first pixel
        set_config(16'hFFFF, 1'b0);
        queue_pixel(32'd0, 1'b1, 1'b0, 1'b1);
        queue_pixel(32'd9, 1'b0, 1'b0, 1'b0);
        queue_pixel(32'd10, 1'b0, 1'b0, 1'b0);
        queue_pixel(32'd65535, 1'b0, 1'b0, 1'b0);
        queue_pixel(32'd12345, 1'b0, 1'b1, 1'b0);
        queue_pixel(32'h8000_0000, 1'b1, 1'b1, 1'b0);
        queue_pixel(32'd70000, 1'b1, 1'b0, 1'b0);

        // text, smallest max value, error on the last pixel
        set_config(16'd1, 1'b0);
        queue_pixel(32'd1, 1'b1, 1'b0, 1'b0);
        queue_pixel(32'd0, 1'b0, 1'b0, 1'b0);
        queue_pixel(32'd2, 1'b0, 1'b1, 1'b0);
        queue_pixel(32'd1, 1'b1, 1'b1, 1'b0);

        run_phase(16'hFFFF, 1'b0, 0, 0);
        run_phase(16'd255, 1'b1, 55, 0);
        run_phase(16'd1, 1'b0, 0, 55);
        run_phase(16'd300, 1'b1, 26, 26);
        run_phase(16'd9, 1'b0, 0, 0);
        run_phase(16'hFFFF, 1'b1, 55, 0);
        run_phase(16'd1, 1'b1, 0, 55);
        run_phase(16'd1000, 1'b0, 26, 26);

        drain_outputs();
        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/pps_pkg.sv
rtl/pps_in_if.sv
rtl/pps_out_if.sv
rtl/pps_apb_regs.sv
rtl/pps_ctrl.sv
rtl/pps_datapath.sv
rtl/pgm_pixel_serializer_core.sv
rtl/pps_checker.sv
verif/tb_pgm_pixel_serializer_core.sv
